// File: rtl/aes_rr_pkg.sv
// ----------------------------------------------------------------------------
// aes_rr_pkg
// Types, constants and byte functions shared by the reduced-round AES blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_rr_pkg;

    typedef struct packed {
        logic [63:0] plaintext_high;
        logic [63:0] plaintext_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] ciphertext_high;
        logic [63:0] ciphertext_low;
    } out_item_t;

    localparam logic [1:0] REG_KEY_HIGH   = 2'd0;
    localparam logic [1:0] REG_KEY_LOW    = 2'd1;
    localparam logic [1:0] REG_ROUND_CNT  = 2'd2;
    localparam logic [1:0] REG_LAST_MIX   = 2'd3;

    localparam logic [3:0] ROUNDS_MIN = 4'd1;
    localparam logic [3:0] ROUNDS_MAX = 4'd10;
    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] GF_POLY    = 8'h1b;

    // controller to datapath
    typedef struct packed {
        logic load;       // take plaintext, add key 0
        logic round;      // perform one round
        logic mix;        // include mixcolumns in this round
    } dp_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

`default_nettype wire

// File: rtl/aes_rr_datapath.sv
// ----------------------------------------------------------------------------
// aes_rr_datapath
// State and round key registers with one shared round unit and key step.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_rr_datapath (
    input  wire logic                 aclk,
    input  wire aes_rr_pkg::dp_cmd_t  cmd,
    input  wire aes_rr_pkg::in_item_t in_item,
    input  wire logic [127:0]         key,
    output aes_rr_pkg::out_item_t     out_item
);

    logic [127:0] state_reg, state_next;
    logic [127:0] rkey_reg, rkey_next;
    logic [7:0]   rcon_reg, rcon_next;

    logic [7:0] s  [16];
    logic [7:0] k  [16];
    logic [7:0] nk [16];
    logic [7:0] t  [16];
    logic [7:0] m  [16];
    logic [127:0] rnd;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = state_reg[127 - 8*i -: 8];
            k[i] = rkey_reg[127 - 8*i -: 8];
        end
        // key schedule step
        nk[0] = k[0] ^ aes_rr_pkg::SBOX[k[13]] ^ rcon_reg;
        nk[1] = k[1] ^ aes_rr_pkg::SBOX[k[14]];
        nk[2] = k[2] ^ aes_rr_pkg::SBOX[k[15]];
        nk[3] = k[3] ^ aes_rr_pkg::SBOX[k[12]];
        for (int i = 4; i < 16; i++) begin
            nk[i] = k[i] ^ nk[i-4];
        end
        // subbytes and shiftrows
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4*c] = aes_rr_pkg::SBOX[s[r + 4*((c + r) & 3)]];
            end
        end
        for (int c = 0; c < 16; c += 4) begin
            logic [7:0] all;
            all = t[c] ^ t[c+1] ^ t[c+2] ^ t[c+3];
            m[c]   = t[c]   ^ all ^ aes_rr_pkg::gf_double(t[c]   ^ t[c+1]);
            m[c+1] = t[c+1] ^ all ^ aes_rr_pkg::gf_double(t[c+1] ^ t[c+2]);
            m[c+2] = t[c+2] ^ all ^ aes_rr_pkg::gf_double(t[c+2] ^ t[c+3]);
            m[c+3] = t[c+3] ^ all ^ aes_rr_pkg::gf_double(t[c+3] ^ t[c]);
        end
        for (int i = 0; i < 16; i++) begin
            rnd[127 - 8*i -: 8] = (cmd.mix ? m[i] : t[i]) ^ nk[i];
        end
    end

    always_comb begin
        state_next = state_reg;
        rkey_next  = rkey_reg;
        rcon_next  = rcon_reg;
        if (cmd.load) begin
            state_next = {in_item.plaintext_high, in_item.plaintext_low} ^ key;
            rkey_next  = key;
            rcon_next  = aes_rr_pkg::RCON_FIRST;
        end else if (cmd.round) begin
            state_next = rnd;
            for (int i = 0; i < 16; i++) begin
                rkey_next[127 - 8*i -: 8] = nk[i];
            end
            rcon_next  = aes_rr_pkg::gf_double(rcon_reg);
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
        rkey_reg  <= rkey_next;
        rcon_reg  <= rcon_next;
    end

    assign out_item.ciphertext_high = state_reg[127:64];
    assign out_item.ciphertext_low  = state_reg[63:0];

endmodule

`default_nettype wire

// File: rtl/aes_rr_ctrl.sv
// ----------------------------------------------------------------------------
// aes_rr_ctrl
// Sequencer: accepts a block, steps the rounds, holds the result for transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_rr_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire logic [3:0]          round_count,
    input  wire logic                last_round_mixes,
    output aes_rr_pkg::dp_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] rnd_reg, rnd_next;
    logic       last;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DONE);
    assign last    = (rnd_reg == round_count);

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    rnd_next   = aes_rr_pkg::ROUNDS_MIN;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.round = 1'b1;
                cmd.mix   = !last || last_round_mixes;
                rnd_next  = rnd_reg + 4'd1;
                if (last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/aes128_reduced_round_encrypt_top.sv
// the result is held for transfer once the load and round_count rounds are done; a new block
// is accepted only after the previous result has been transferred, as the single shared
// round unit performs one round per cycle
// reset (aresetn low, synchronous): key 0, 10 rounds, last round without
// mixcolumns, sequencer idle
// ----------------------------------------------------------------------------
// aes128_reduced_round_encrypt_top
// AES-128 encryption over a configurable round count with on-the-fly keys.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_reduced_round_encrypt_top (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [63:0]           cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire aes_rr_pkg::in_item_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output aes_rr_pkg::out_item_t      m_data
);

    logic [63:0] key_high_reg, key_low_reg;
    logic [3:0]  round_count_reg;
    logic        last_mix_reg;
    aes_rr_pkg::dp_cmd_t cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg    <= '0;
            key_low_reg     <= '0;
            round_count_reg <= aes_rr_pkg::ROUNDS_MAX;
            last_mix_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                aes_rr_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aes_rr_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                aes_rr_pkg::REG_ROUND_CNT: begin
                    if (cfg_data[3:0] < aes_rr_pkg::ROUNDS_MIN) begin
                        round_count_reg <= aes_rr_pkg::ROUNDS_MIN;
                    end else if (cfg_data[3:0] > aes_rr_pkg::ROUNDS_MAX) begin
                        round_count_reg <= aes_rr_pkg::ROUNDS_MAX;
                    end else begin
                        round_count_reg <= cfg_data[3:0];
                    end
                end
                aes_rr_pkg::REG_LAST_MIX: last_mix_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    aes_rr_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .round_count      (round_count_reg),
        .last_round_mixes (last_mix_reg),
        .cmd              (cmd)
    );

    aes_rr_datapath u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .in_item  (s_data),
        .key      ({key_high_reg, key_low_reg}),
        .out_item (m_data)
    );

endmodule

`default_nettype wire
